>>> sv/tpd_pkg.sv
package tpd_pkg;

    localparam int PadW   = 4;
    localparam int ChanW  = 3;
    localparam int TimeW  = 32;
    localparam int ThreshW = 8;

    localparam logic [ThreshW-1:0] THRESHOLD_RESET = 8'd3;

    // Pad bit positions in a mask
    localparam int PAD_UP_BIT    = 0;
    localparam int PAD_DOWN_BIT  = 1;
    localparam int PAD_LEFT_BIT  = 2;
    localparam int PAD_RIGHT_BIT = 3;

    localparam logic [PadW-1:0] PAD_UP    = 4'b0001;
    localparam logic [PadW-1:0] PAD_DOWN  = 4'b0010;
    localparam logic [PadW-1:0] PAD_LEFT  = 4'b0100;
    localparam logic [PadW-1:0] PAD_RIGHT = 4'b1000;

    // Event channel codes
    localparam logic [ChanW-1:0] CH_NONE  = 3'd0;
    localparam logic [ChanW-1:0] CH_UP    = 3'd1;
    localparam logic [ChanW-1:0] CH_DOWN  = 3'd2;
    localparam logic [ChanW-1:0] CH_LEFT  = 3'd3;
    localparam logic [ChanW-1:0] CH_RIGHT = 3'd4;

    typedef logic [PadW-1:0]  pad_mask_t;
    typedef logic [ChanW-1:0] chan_t;
    typedef logic [TimeW-1:0] tick_t;

endpackage

>>> sv/tpd_in_if.sv
interface tpd_in_if;
    import tpd_pkg::*;

    logic      valid;
    logic      ready;
    pad_mask_t pad_mask;
    tick_t     now_ms;

    modport source (output valid, output pad_mask, output now_ms, input ready);
    modport sink   (input valid, input pad_mask, input now_ms, output ready);
endinterface

>>> sv/tpd_out_if.sv
interface tpd_out_if;
    import tpd_pkg::*;

    logic      valid;
    logic      ready;
    chan_t     channel;
    logic      pressed;
    tick_t     press_tick;
    tick_t     release_tick;
    pad_mask_t confirmed_mask;

    modport source (
        output valid, output channel, output pressed, output press_tick,
        output release_tick, output confirmed_mask, input ready
    );
    modport sink (
        input valid, input channel, input pressed, input press_tick,
        input release_tick, input confirmed_mask, output ready
    );
endinterface

>>> sv/tpd_resolve.sv
module tpd_resolve (
    input  tpd_pkg::pad_mask_t mask,
    input  tpd_pkg::pad_mask_t prev_mask,
    output tpd_pkg::chan_t     channel
);
    import tpd_pkg::*;

    // Order up, down, left, right
    function automatic chan_t chan_direct(input pad_mask_t m);
        chan_t c;
        if (m[PAD_UP_BIT])
            c = CH_UP;
        else if (m[PAD_DOWN_BIT])
            c = CH_DOWN;
        else if (m[PAD_LEFT_BIT])
            c = CH_LEFT;
        else if (m[PAD_RIGHT_BIT])
            c = CH_RIGHT;
        else
            c = CH_NONE;
        return c;
    endfunction

    // Order down, up, left, right
    function automatic chan_t chan_priority(input pad_mask_t m);
        chan_t c;
        if (m[PAD_DOWN_BIT])
            c = CH_DOWN;
        else if (m[PAD_UP_BIT])
            c = CH_UP;
        else if (m[PAD_LEFT_BIT])
            c = CH_LEFT;
        else if (m[PAD_RIGHT_BIT])
            c = CH_RIGHT;
        else
            c = CH_NONE;
        return c;
    endfunction

    pad_mask_t rising;
    logic      mask_single;
    logic      rise_single;
    logic      rise_multi;

    assign rising      = mask & ~prev_mask;
    assign mask_single = $onehot(mask);
    assign rise_single = $onehot(rising);
    assign rise_multi  = (rising != '0) && !rise_single;

    always_comb
    begin
        if (mask == '0)
            channel = CH_NONE;
        else if (mask_single)
            channel = chan_direct(mask);
        else if (rise_single)
            channel = chan_direct(rising);
        else if (rise_multi)
            channel = chan_priority(rising);
        else if (mask == (PAD_UP | PAD_DOWN))
            // held pair: slide continues away from the pad held alone before
            channel = (prev_mask == PAD_UP) ? CH_DOWN : CH_UP;
        else if (mask == (PAD_LEFT | PAD_RIGHT))
            channel = (prev_mask == PAD_LEFT) ? CH_RIGHT : CH_LEFT;
        else
            channel = chan_priority(mask);
    end
endmodule

>>> sv/touch_pad_debounce_event.sv
// Touch pad debouncer and event generator. Each transfer on poll carries a
// 4-bit raw pad mask (bit0 up, bit1 down, bit2 left, bit3 right) and a
// millisecond tick; each one yields exactly one transfer on evt with the
// resolved channel, press/hold/release flag, press and release ticks and the
// debounced mask. A mask is confirmed once threshold equal samples in a row
// have been seen (a new mask counts as the first, so at least two are needed).
// A change of channel while pressed gives a release, and the following poll
// gives the new press without being debounced. One poll is taken per clock
// while evt is not stalled; a poll waits in the input register until the
// result stage is free for it. The threshold is written through
// threshold_we/threshold_wdata (reset 3) and must only change while idle.
module touch_pad_debounce_event (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                threshold_we,
    input  logic [7:0]          threshold_wdata,
    tpd_in_if.sink              poll,
    tpd_out_if.source           evt
);
    import tpd_pkg::*;

    logic [ThreshW-1:0] threshold_reg;

    // input stage
    logic      s1_valid_reg;
    pad_mask_t s1_mask_reg;
    tick_t     s1_now_reg;

    // persistent state
    pad_mask_t          candidate_reg, candidate_next;
    logic [ThreshW-1:0] count_reg, count_next;
    pad_mask_t          stable_reg, stable_next;
    pad_mask_t          prev_stable_reg, prev_stable_next;
    chan_t              held_chan_reg, held_chan_next;
    logic               held_reg, held_next;
    tick_t              held_time_reg, held_time_next;
    chan_t              queued_reg, queued_next;

    // result stage
    logic      out_valid_reg;
    chan_t     out_chan_reg, out_chan_next;
    logic      out_pressed_reg, out_pressed_next;
    tick_t     out_ptime_reg, out_ptime_next;
    tick_t     out_rtime_reg, out_rtime_next;

    logic               advance;
    logic [ThreshW-1:0] count_inc;
    pad_mask_t          db_stable;
    chan_t              res_chan;

    assign advance    = s1_valid_reg && (!out_valid_reg || evt.ready);
    assign poll.ready = !s1_valid_reg || advance;

    assign evt.valid          = out_valid_reg;
    assign evt.channel        = out_chan_reg;
    assign evt.pressed        = out_pressed_reg;
    assign evt.press_tick     = out_ptime_reg;
    assign evt.release_tick   = out_rtime_reg;
    assign evt.confirmed_mask = stable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (threshold_we)
            threshold_reg <= threshold_wdata;
    end

    // Debounce step: feeds the resolver with the stable mask after this poll
    always_comb
    begin
        count_inc = (count_reg < threshold_reg) ? count_reg + 1'b1 : count_reg;
        db_stable = stable_reg;
        if (s1_mask_reg == candidate_reg)
        begin
            if (count_inc >= threshold_reg)
                db_stable = candidate_reg;
        end
    end

    tpd_resolve u_resolve (
        .mask      (db_stable),
        .prev_mask (prev_stable_reg),
        .channel   (res_chan)
    );

    always_comb
    begin
        candidate_next   = candidate_reg;
        count_next       = count_reg;
        stable_next      = stable_reg;
        prev_stable_next = prev_stable_reg;
        held_chan_next   = held_chan_reg;
        held_next        = held_reg;
        held_time_next   = held_time_reg;
        queued_next      = queued_reg;
        out_chan_next    = CH_NONE;
        out_pressed_next = 1'b0;
        out_ptime_next   = '0;
        out_rtime_next   = '0;

        if (queued_reg != CH_NONE)
        begin
            // emit the queued press; this poll's mask is dropped
            out_chan_next    = queued_reg;
            out_pressed_next = 1'b1;
            out_ptime_next   = s1_now_reg;
            held_chan_next   = queued_reg;
            held_next        = 1'b1;
            held_time_next   = s1_now_reg;
            queued_next      = CH_NONE;
        end
        else
        begin
            if (s1_mask_reg == candidate_reg)
                count_next = count_inc;
            else
            begin
                candidate_next = s1_mask_reg;
                count_next     = 8'd1;
            end
            stable_next      = db_stable;
            prev_stable_next = db_stable;

            if (res_chan != CH_NONE)
            begin
                if (!held_reg)
                begin
                    out_chan_next    = res_chan;
                    out_pressed_next = 1'b1;
                    out_ptime_next   = s1_now_reg;
                    held_chan_next   = res_chan;
                    held_next        = 1'b1;
                    held_time_next   = s1_now_reg;
                end
                else if (res_chan != held_chan_reg)
                begin
                    // release the old channel, queue the new press
                    out_chan_next  = held_chan_reg;
                    out_ptime_next = held_time_reg;
                    out_rtime_next = s1_now_reg;
                    queued_next    = res_chan;
                    held_chan_next = CH_NONE;
                    held_next      = 1'b0;
                    held_time_next = '0;
                end
                else
                begin
                    out_chan_next    = held_chan_reg;
                    out_pressed_next = 1'b1;
                    out_ptime_next   = held_time_reg;
                end
            end
            else if (held_reg)
            begin
                out_chan_next  = held_chan_reg;
                out_ptime_next = held_time_reg;
                out_rtime_next = s1_now_reg;
                held_chan_next = CH_NONE;
                held_next      = 1'b0;
                held_time_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            candidate_reg   <= '0;
            count_reg       <= '0;
            stable_reg      <= '0;
            prev_stable_reg <= '0;
            held_chan_reg   <= CH_NONE;
            held_reg        <= 1'b0;
            held_time_reg   <= '0;
            queued_reg      <= CH_NONE;
        end
        else
        begin
            if (poll.valid && poll.ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (evt.ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                candidate_reg   <= candidate_next;
                count_reg       <= count_next;
                stable_reg      <= stable_next;
                prev_stable_reg <= prev_stable_next;
                held_chan_reg   <= held_chan_next;
                held_reg        <= held_next;
                held_time_reg   <= held_time_next;
                queued_reg      <= queued_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            s1_mask_reg <= poll.pad_mask;
            s1_now_reg  <= poll.now_ms;
        end
        if (advance)
        begin
            out_chan_reg    <= out_chan_next;
            out_pressed_reg <= out_pressed_next;
            out_ptime_reg   <= out_ptime_next;
            out_rtime_reg   <= out_rtime_next;
        end
    end
endmodule

>>> tb/touch_pad_debounce_event_test.sv
module touch_pad_debounce_event_test;
    import tpd_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 100;

    typedef struct packed {
        chan_t     channel;
        logic      pressed;
        tick_t     press_tick;
        tick_t     release_tick;
        pad_mask_t confirmed_mask;
    } pad_event_t;

    typedef struct packed {
        pad_mask_t  mask;
        tick_t      now;
        logic       typed;
        pad_event_t ev;
    } poll_row_t;

    logic               clk;
    logic               rst_n;
    logic               threshold_we;
    logic [ThreshW-1:0] threshold_wdata;

    tpd_in_if  poll_if ();
    tpd_out_if evt_if ();

    touch_pad_debounce_event u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .threshold_we    (threshold_we),
        .threshold_wdata (threshold_wdata),
        .poll            (poll_if.sink),
        .evt             (evt_if.source)
    );

    // Debouncer and event state as the block should hold it
    logic [ThreshW-1:0] db_threshold;
    pad_mask_t          db_candidate;
    logic [7:0]         db_run;
    pad_mask_t          db_stable;
    pad_mask_t          db_prev;
    chan_t              hold_chan;
    logic               hold_on;
    tick_t              hold_since;
    chan_t              queued_chan;

    pad_event_t pending_events[$];
    poll_row_t  poll_rows[$];
    pad_event_t predicted;
    pad_event_t wanted;
    pad_event_t row_event;
    logic       row_typed;
    logic       poll_took;
    logic       steady;
    tick_t      tick_now;
    int         mismatches;
    int         cycle_count;
    int         stall_req;
    int         stall_ack;

    always #2 clk = ~clk;

    // Up first, or down first when asked; single pads come out the same either way
    function automatic chan_t first_in_order(pad_mask_t m, logic down_first);
        if (down_first && m[PAD_DOWN_BIT]) return CH_DOWN;
        if (m[PAD_UP_BIT]) return CH_UP;
        if (m[PAD_DOWN_BIT]) return CH_DOWN;
        if (m[PAD_LEFT_BIT]) return CH_LEFT;
        if (m[PAD_RIGHT_BIT]) return CH_RIGHT;
        return CH_NONE;
    endfunction

    function automatic pad_event_t next_pad_event(pad_mask_t raw, tick_t now);
        pad_event_t ev;
        pad_mask_t  rising;
        chan_t      want;
        ev = '0;
        if (queued_chan != CH_NONE)
        begin
            // queued press: the poll's mask is dropped and the debouncer holds
            hold_chan   = queued_chan;
            hold_on     = 1'b1;
            hold_since  = now;
            queued_chan = CH_NONE;
            ev.channel    = hold_chan;
            ev.pressed    = 1'b1;
            ev.press_tick = now;
        end
        else
        begin
            if (raw == db_candidate)
            begin
                if (db_run < db_threshold) db_run = db_run + 8'd1;
                if (db_run >= db_threshold) db_stable = db_candidate;
            end
            else
            begin
                db_candidate = raw;
                db_run       = 8'd1;
            end
            rising = db_stable & ~db_prev;
            if ($countones(db_stable) <= 1)
                want = first_in_order(db_stable, 1'b0);
            else if ($countones(rising) == 1)
                want = first_in_order(rising, 1'b0);
            else if ($countones(rising) > 1)
                want = first_in_order(rising, 1'b1);
            else if (db_stable == (PAD_UP | PAD_DOWN))
                want = (db_prev == PAD_UP) ? CH_DOWN : CH_UP;
            else if (db_stable == (PAD_LEFT | PAD_RIGHT))
                want = (db_prev == PAD_LEFT) ? CH_RIGHT : CH_LEFT;
            else
                want = first_in_order(db_stable, 1'b1);
            db_prev = db_stable;

            if (hold_on && want != hold_chan)
            begin
                // release the old channel and queue the new one, if any
                ev.channel      = hold_chan;
                ev.press_tick   = hold_since;
                ev.release_tick = now;
                queued_chan     = want;
                hold_chan       = CH_NONE;
                hold_on         = 1'b0;
                hold_since      = '0;
            end
            else if (want != CH_NONE)
            begin
                if (!hold_on)
                begin
                    hold_chan  = want;
                    hold_on    = 1'b1;
                    hold_since = now;
                end
                ev.channel    = hold_chan;
                ev.pressed    = 1'b1;
                ev.press_tick = hold_since;
            end
        end
        ev.confirmed_mask = db_stable;
        return ev;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0h, want %0h",
                     cycle_count, what, got, exp_val);
    endtask

    always @(posedge clk)
    begin
        poll_took <= rst_n && poll_if.valid && poll_if.ready;
        if (rst_n && poll_if.valid && poll_if.ready)
        begin
            predicted = next_pad_event(poll_if.pad_mask, poll_if.now_ms);
            pending_events.push_back(row_typed ? row_event : predicted);
        end
        if (rst_n && evt_if.valid && evt_if.ready)
        begin
            if (pending_events.size() == 0)
                report_mismatch("event with nothing pending", 32'd0, 32'd0);
            else
            begin
                wanted = pending_events.pop_front();
                if (evt_if.channel !== wanted.channel)
                    report_mismatch("channel", 32'(evt_if.channel), 32'(wanted.channel));
                if (evt_if.pressed !== wanted.pressed)
                    report_mismatch("pressed", 32'(evt_if.pressed), 32'(wanted.pressed));
                if (evt_if.press_tick !== wanted.press_tick)
                    report_mismatch("press_tick", evt_if.press_tick, wanted.press_tick);
                if (evt_if.release_tick !== wanted.release_tick)
                    report_mismatch("release_tick", evt_if.release_tick,
                                    wanted.release_tick);
                if (evt_if.confirmed_mask !== wanted.confirmed_mask)
                    report_mismatch("confirmed_mask", 32'(evt_if.confirmed_mask),
                                    32'(wanted.confirmed_mask));
            end
        end
    end

    // Receiver: mostly ready, short and long stalls, and one long hold-off on request
    initial
    begin
        evt_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_req != stall_ack)
            begin
                evt_if.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                stall_ack = stall_req;
            end
            else if (steady || $urandom_range(0, 99) < 75)
                evt_if.ready = 1'b1;
            else
            begin
                evt_if.ready = 1'b0;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(4, 40)) @(negedge clk);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Present one poll, hold it until the transfer, then idle at random
    task automatic offer_poll(input pad_mask_t mask, input tick_t now, input logic typed,
                              input pad_event_t ev);
        int gap_roll;
        poll_if.valid    = 1'b1;
        poll_if.pad_mask = mask;
        poll_if.now_ms   = now;
        row_typed        = typed;
        row_event        = ev;
        @(negedge clk);
        while (!poll_took) @(negedge clk);
        gap_roll = $urandom_range(0, 99);
        if (!steady && gap_roll >= 70)
        begin
            poll_if.valid = 1'b0;
            repeat (gap_roll < 95 ? $urandom_range(1, 3) : $urandom_range(5, 40))
                @(negedge clk);
        end
    endtask

    task automatic add_row(input pad_mask_t mask, input tick_t now, input logic typed,
                           input chan_t ch, input logic pr, input tick_t pt,
                           input tick_t rt, input pad_mask_t cm);
        poll_row_t row;
        row.mask                 = mask;
        row.now                  = now;
        row.typed                = typed;
        row.ev.channel           = ch;
        row.ev.pressed           = pr;
        row.ev.press_tick        = pt;
        row.ev.release_tick      = rt;
        row.ev.confirmed_mask    = cm;
        poll_rows.push_back(row);
    endtask

    // Drop the offer, then wait until every transfer has come out
    task automatic settle();
        poll_if.valid = 1'b0;
        while (pending_events.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [ThreshW-1:0] value);
        settle();
        threshold_we    = 1'b1;
        threshold_wdata = value;
        @(negedge clk);
        threshold_we = 1'b0;
        db_threshold = value;
    endtask

    // Mostly runs long enough to confirm, some cut short, some single-sample noise
    task automatic run_phase(input logic [ThreshW-1:0] thr, input int budget,
                             input logic calm, input int stall_at);
        int        sent;
        int        span;
        int        kind;
        pad_mask_t mask;
        write_threshold(thr);
        steady = calm;
        sent   = 0;
        while (sent < budget)
        begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 1)
                mask = PAD_UP << $urandom_range(0, 3);
            else
                mask = pad_mask_t'($urandom);
            if (kind < 75)
                span = thr + 1 + $urandom_range(0, 3);
            else if (kind < 90)
                span = $urandom_range(1, thr);
            else
                span = 1;
            if (span > budget - sent)
                span = budget - sent;
            repeat (span)
            begin
                if (sent == stall_at) stall_req++;
                tick_now = tick_now + $urandom_range(0, 20);
                if ($urandom_range(0, 49) == 0) tick_now = $urandom;
                offer_poll(mask, tick_now, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        threshold_we     = 1'b0;
        threshold_wdata  = '0;
        poll_if.valid    = 1'b0;
        poll_if.pad_mask = '0;
        poll_if.now_ms   = '0;
        row_typed        = 1'b0;
        row_event        = '0;
        steady           = 1'b0;
        mismatches       = 0;
        stall_req        = 0;
        stall_ack        = 0;
        db_threshold     = THRESHOLD_RESET;
        db_candidate     = '0;
        db_run           = '0;
        db_stable        = '0;
        db_prev          = '0;
        hold_chan        = CH_NONE;
        hold_on          = 1'b0;
        hold_since       = '0;
        queued_chan      = CH_NONE;

        // Reset threshold of three: a mask confirms on its third sample
        add_row(4'h0, 32'd0, 1'b1, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h1, 32'd1, 1'b1, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h1, 32'd2, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h1, 32'd3, 1'b1, CH_UP, 1'b1, 32'd3, 32'd0, 4'h1);
        add_row(4'h3, 32'd4, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h3, 32'd5, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        // down rises while up is held: release up, queue down
        add_row(4'h3, 32'd6, 1'b1, CH_UP, 1'b0, 32'd3, 32'd6, 4'h3);
        // queued press ignores the poll's mask
        add_row(4'h8, 32'd7, 1'b1, CH_DOWN, 1'b1, 32'd7, 32'd0, 4'h3);
        add_row(4'hF, 32'hFFFF_FFFF, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'hF, 32'd0, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'hF, 32'd10, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'hF, 32'd11, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'hC, 32'd12, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'hC, 32'd13, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'hC, 32'd14, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'hC, 32'd15, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'hC, 32'd16, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h0, 32'd17, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h0, 32'd18, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h0, 32'd19, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h8, 32'd20, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h8, 32'd21, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h8, 32'd22, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h8, 32'd23, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);
        add_row(4'h2, 32'd24, 1'b0, CH_NONE, 1'b0, 32'd0, 32'd0, 4'h0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (poll_rows[i])
            offer_poll(poll_rows[i].mask, poll_rows[i].now, poll_rows[i].typed,
                       poll_rows[i].ev);

        tick_now = $urandom;
        run_phase(8'd1, 300, 1'b0, -1);
        run_phase(8'd255, 560, 1'b0, -1);
        run_phase(8'd2, 300, 1'b0, 120);
        run_phase(8'd5, 300, 1'b1, -1);
        run_phase(8'($urandom_range(1, 8)), 200, 1'b0, -1);
        run_phase(8'($urandom_range(1, 8)), 200, 1'b0, -1);

        poll_if.valid = 1'b0;
        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/tpd_pkg.sv
sv/tpd_in_if.sv
sv/tpd_out_if.sv
sv/tpd_resolve.sv
sv/touch_pad_debounce_event.sv
tb/touch_pad_debounce_event_test.sv
